@@ rtl/core/tmlr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmlr_pkg
// Shared codes and inter-stage types for the scrolling tile layer renderer.
// ----------------------------------------------------------------------------
package tmlr_pkg;

  localparam logic [1:0] FUNC_MAP_WR = 2'd0;
  localparam logic [1:0] FUNC_PAT_WR = 2'd1;
  localparam logic [1:0] FUNC_RENDER = 2'd2;

  localparam logic [1:0] CFG_SCROLL_X    = 2'd0;
  localparam logic [1:0] CFG_SCROLL_Y    = 2'd1;
  localparam logic [1:0] CFG_TRANSPARENT = 2'd2;

  localparam int unsigned WORLD_W    = 9;
  localparam int unsigned MAP_AW     = 12;
  localparam int unsigned CODE_W     = 14;
  localparam int unsigned MEM_AW     = 15;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned SX_W       = 9;
  localparam int unsigned SY_W       = 8;
  localparam int unsigned INDEX_W    = 11;
  localparam int unsigned PEN_W      = 4;
  localparam int unsigned COLOR_W    = INDEX_W - PEN_W;
  localparam logic [8:0]  VIS_Y0     = 9'd8;
  localparam int unsigned FLIPY_BIT  = 31;
  localparam int unsigned FLIPX_BIT  = 30;
  localparam int unsigned COLOR_LSB  = 16;

  typedef struct packed {
    logic                valid;
    logic [SX_W-1:0]     sx;
    logic [SY_W-1:0]     sy;
    logic [COLOR_W-1:0]  color;
    logic [2:0]          col;
  } pix_req_t;

  typedef struct packed {
    logic            valid;
    logic [SX_W-1:0] sx;
    logic [SY_W-1:0] sy;
    logic [2:0]      row;
    logic [2:0]      col;
  } map_req_t;

endpackage

@@ rtl/core/scrolling_tilemap_layer_render.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrolling_tilemap_layer_render
// Scrolling 8x8 tile, 4bpp layer over a wrapping 512x512 world.
//
//   port group    direction  handshake                payload
//   command       in         start & !busy            func, mem_addr, mem_data,
//                                                     screen_x, screen_y
//   config        in         cfg_we                   cfg_idx, cfg_data
//   result        out        result_strobe (1 cycle)  pixel_index, pixel_write,
//                                                     out_x, out_y
//
// One command beat per cycle; busy is never raised.
// A render result passes through the map RAM read, then the
// pattern RAM read, then the result register.
// Writes land at the end of their cycle; a later render sees them.
// Synchronous reset clears the pipeline valids and the config registers.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module scrolling_tilemap_layer_render #(
  parameter int TILE_COUNT = 4096,
  parameter int SCREEN_W = 320,
  parameter int SCREEN_H = 240
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   func,
  input  logic [tmlr_pkg::MEM_AW-1:0]  mem_addr,
  input  logic [tmlr_pkg::WORD_W-1:0]  mem_data,
  input  logic [tmlr_pkg::SX_W-1:0]    screen_x,
  input  logic [tmlr_pkg::SY_W-1:0]    screen_y,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_idx,
  input  logic [tmlr_pkg::WORLD_W-1:0] cfg_data,
  output logic                         result_strobe,
  output logic [tmlr_pkg::INDEX_W-1:0] pixel_index,
  output logic                         pixel_write,
  output logic [tmlr_pkg::SX_W-1:0]    out_x,
  output logic [tmlr_pkg::SY_W-1:0]    out_y
);
  import tmlr_pkg::*;

  localparam int PAT_AW = $clog2(TILE_COUNT * 8);

  logic               accept;
  logic               on_screen;
  logic               render;
  logic               map_we;
  logic               pat_wr;
  logic [WORLD_W-1:0] scroll_x;
  logic [WORLD_W-1:0] scroll_y;
  logic               transparent_mode;
  logic [PAT_AW-1:0]  pat_raddr;
  pix_req_t           pix_req;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign on_screen = (32'(screen_x) < 32'(SCREEN_W)) && (32'(screen_y) < 32'(SCREEN_H));
  assign render    = accept && (func == FUNC_RENDER) && on_screen;
  assign map_we    = accept && (func == FUNC_MAP_WR);
  assign pat_wr    = accept && (func == FUNC_PAT_WR);

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_x         <= '0;
      scroll_y         <= '0;
      transparent_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SCROLL_X:    scroll_x <= cfg_data;
        CFG_SCROLL_Y:    scroll_y <= cfg_data;
        CFG_TRANSPARENT: transparent_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tmlr_map_stage #(.TILE_COUNT(TILE_COUNT)) u_map_stage (
    .clk       (clk),
    .rst       (rst),
    .map_we    (map_we),
    .render    (render),
    .mem_addr  (mem_addr),
    .mem_data  (mem_data),
    .screen_x  (screen_x),
    .screen_y  (screen_y),
    .scroll_x  (scroll_x),
    .scroll_y  (scroll_y),
    .pat_raddr (pat_raddr),
    .pix_req   (pix_req)
  );

  tmlr_pat_stage #(.TILE_COUNT(TILE_COUNT)) u_pat_stage (
    .clk              (clk),
    .rst              (rst),
    .pat_wr           (pat_wr),
    .mem_addr         (mem_addr),
    .mem_data         (mem_data),
    .pat_raddr        (pat_raddr),
    .pix_req          (pix_req),
    .transparent_mode (transparent_mode),
    .result_strobe    (result_strobe),
    .pixel_index      (pixel_index),
    .pixel_write      (pixel_write),
    .out_x            (out_x),
    .out_y            (out_y)
  );

  a_result_follows_render: assert property (@(posedge clk) disable iff (rst)
    render |-> ##3 (result_strobe && out_x == $past(screen_x, 3) && out_y == $past(screen_y, 3)))
    else $error("render beat lost or misplaced");

  a_no_result_for_write: assert property (@(posedge clk) disable iff (rst)
    (accept && func != FUNC_RENDER) |-> ##3 !result_strobe)
    else $error("result from a non-render beat");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(render, 3))
    else $error("result without a render beat");

  a_opaque_always_writes: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !transparent_mode && $stable(transparent_mode)) |-> pixel_write)
    else $error("opaque layer dropped a pixel");

endmodule

@@ rtl/core/tmlr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmlr_ram
// Generic single-port-write, single-port-read RAM, registered read, old data
// returned on a same-address read and write.
// ----------------------------------------------------------------------------
module tmlr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/tmlr_map_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmlr_map_stage
// World position, tile map lookup, flips and pattern row address.
// ----------------------------------------------------------------------------
module tmlr_map_stage #(
  parameter int TILE_COUNT = 4096,
  localparam int PAT_DEPTH = TILE_COUNT * 8,
  localparam int PAT_AW = $clog2(PAT_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         map_we,
  input  logic                         render,
  input  logic [tmlr_pkg::MEM_AW-1:0]  mem_addr,
  input  logic [tmlr_pkg::WORD_W-1:0]  mem_data,
  input  logic [tmlr_pkg::SX_W-1:0]    screen_x,
  input  logic [tmlr_pkg::SY_W-1:0]    screen_y,
  input  logic [tmlr_pkg::WORLD_W-1:0] scroll_x,
  input  logic [tmlr_pkg::WORLD_W-1:0] scroll_y,
  output logic [PAT_AW-1:0]            pat_raddr,
  output tmlr_pkg::pix_req_t           pix_req
);
  import tmlr_pkg::*;

  logic [WORLD_W-1:0] wx;
  logic [WORLD_W-1:0] wy;
  logic [MAP_AW-1:0]  map_raddr;
  logic [WORD_W-1:0]  entry;
  map_req_t           s1;
  logic [CODE_W-1:0]  code;
  logic               code_ok;
  logic [2:0]         row_f;
  logic [CODE_W+2:0]  pat_full;

  assign wx        = screen_x + scroll_x;
  assign wy        = WORLD_W'({1'b0, screen_y}) + VIS_Y0 + scroll_y;
  assign map_raddr = {wy[WORLD_W-1:3], wx[WORLD_W-1:3]};

  tmlr_ram #(.WIDTH(WORD_W), .DEPTH(1 << MAP_AW)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (mem_addr[MAP_AW-1:0]),
    .wdata (mem_data),
    .raddr (map_raddr),
    .rdata (entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= render;
    end
    s1.sx  <= screen_x;
    s1.sy  <= screen_y;
    s1.row <= wy[2:0];
    s1.col <= wx[2:0];
  end

  // out-of-range code falls back to tile 0
  assign code     = entry[CODE_W-1:0];
  assign code_ok  = 32'(code) < 32'(TILE_COUNT);
  assign row_f    = entry[FLIPY_BIT] ? ~s1.row : s1.row;
  assign pat_full = {(code_ok ? code : {CODE_W{1'b0}}), row_f};
  assign pat_raddr = pat_full[PAT_AW-1:0];

  always_comb begin
    pix_req.valid = s1.valid;
    pix_req.sx    = s1.sx;
    pix_req.sy    = s1.sy;
    pix_req.color = entry[COLOR_LSB +: COLOR_W];
    pix_req.col   = entry[FLIPX_BIT] ? ~s1.col : s1.col;
  end

endmodule

@@ rtl/core/tmlr_pat_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmlr_pat_stage
// Pattern memory, pen extraction and result register.
// ----------------------------------------------------------------------------
module tmlr_pat_stage #(
  parameter int TILE_COUNT = 4096,
  localparam int PAT_DEPTH = TILE_COUNT * 8,
  localparam int PAT_AW = $clog2(PAT_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pat_wr,
  input  logic [tmlr_pkg::MEM_AW-1:0]  mem_addr,
  input  logic [tmlr_pkg::WORD_W-1:0]  mem_data,
  input  logic [PAT_AW-1:0]            pat_raddr,
  input  tmlr_pkg::pix_req_t           pix_req,
  input  logic                         transparent_mode,
  output logic                         result_strobe,
  output logic [tmlr_pkg::INDEX_W-1:0] pixel_index,
  output logic                         pixel_write,
  output logic [tmlr_pkg::SX_W-1:0]    out_x,
  output logic [tmlr_pkg::SY_W-1:0]    out_y
);
  import tmlr_pkg::*;

  logic [16:0]       addr_ext;
  logic              pat_we;
  logic [WORD_W-1:0] word;
  pix_req_t          s2;
  logic [PEN_W-1:0]  pen;

  assign addr_ext = {2'b00, mem_addr};
  assign pat_we   = pat_wr && (32'(addr_ext) < 32'(PAT_DEPTH));

  tmlr_ram #(.WIDTH(WORD_W), .DEPTH(PAT_DEPTH)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (addr_ext[PAT_AW-1:0]),
    .wdata (mem_data),
    .raddr (pat_raddr),
    .rdata (word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= pix_req.valid;
    end
    s2.sx    <= pix_req.sx;
    s2.sy    <= pix_req.sy;
    s2.color <= pix_req.color;
    s2.col   <= pix_req.col;
  end

  // pixel 0 in the top nibble
  assign pen = word[{~s2.col, 2'b00} +: PEN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= s2.valid;
    end
    pixel_index <= {s2.color, pen};
    pixel_write <= !(transparent_mode && (pen == '0));
    out_x       <= s2.sx;
    out_y       <= s2.sy;
  end

endmodule
